@@ sv/etc1_pkg.sv @@
// ----------------------------------------------------------------------------
// etc1_pkg
// Shared types, constants and helper functions of the ETC1 block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package etc1_pkg;

    // default depth of the queue between decode and pixel sequencer
    localparam int unsigned QUEUE_DEPTH = 2;

    // stream payload widths
    localparam int unsigned IN_DATA_W  = 128;
    localparam int unsigned OUT_DATA_W = 40;

    // flag and field positions in the low color word
    localparam int unsigned FLIP_BIT = 24;
    localparam int unsigned DIFF_BIT = 25;

    // configuration register index
    localparam logic CFG_ALPHA_EN = 1'b0;

    // modifier magnitudes per table: small and large step
    localparam logic [7:0] MOD_SMALL [8] = '{8'd2, 8'd5, 8'd9, 8'd13,
                                             8'd18, 8'd24, 8'd33, 8'd47};
    localparam logic [7:0] MOD_LARGE [8] = '{8'd8, 8'd17, 8'd29, 8'd42,
                                             8'd60, 8'd80, 8'd106, 8'd183};

    // decoded block as it waits for the pixel sequencer
    typedef struct packed {
        logic [7:0]  base0_r;
        logic [7:0]  base0_g;
        logic [7:0]  base0_b;
        logic [7:0]  base1_r;
        logic [7:0]  base1_g;
        logic [7:0]  base1_b;
        logic [2:0]  tab0;
        logic [2:0]  tab1;
        logic        flip;
        logic [31:0] idx;
        logic [63:0] alpha;
    } t_blk;

    // signed modifier from table and 2-bit pixel code (bit 0 large, bit 1 negative)
    function automatic logic signed [8:0] mod_value(input logic [2:0] tab,
                                                    input logic [1:0] code);
        logic [8:0] mag;
        mag = code[0] ? {1'b0, MOD_LARGE[tab]} : {1'b0, MOD_SMALL[tab]};
        return code[1] ? -$signed(mag) : $signed(mag);
    endfunction

    // base plus modifier, saturated to 0..255
    function automatic logic [7:0] sat_add(input logic [7:0] base,
                                           input logic signed [8:0] m);
        logic signed [9:0] sum;
        logic [7:0] res;
        sum = $signed({2'b00, base}) + $signed({m[8], m});
        if (sum[9]) begin
            res = 8'd0;
        end else if (sum[8]) begin
            res = 8'd255;
        end else begin
            res = sum[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ sv/etc1_front.sv @@
// ----------------------------------------------------------------------------
// etc1_front
// Decodes the header of an ETC1 word: both base colors, tables and flip.
// ----------------------------------------------------------------------------
`default_nettype none

module etc1_front (
    input  wire logic [63:0]     i_color,
    input  wire logic [63:0]     i_alpha,
    output etc1_pkg::t_blk       o_blk
);

    logic [31:0] w_head;

    // 5-bit base plus signed 3-bit delta, clamped to 0..31
    function automatic logic [4:0] diff_sum(input logic [4:0] base,
                                            input logic [2:0] delta);
        logic signed [6:0] sum;
        logic [4:0] res;
        sum = $signed({2'b00, base}) + $signed({{4{delta[2]}}, delta});
        if (sum[6]) begin
            res = 5'd0;
        end else if (sum[5]) begin
            res = 5'd31;
        end else begin
            res = sum[4:0];
        end
        return res;
    endfunction

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] expand4(input logic [3:0] v);
        return {v, v};
    endfunction

    assign w_head = i_color[31:0];

    // base color decode, individual or differential
    always_comb begin
        o_blk = '0;
        if (w_head[etc1_pkg::DIFF_BIT]) begin
            o_blk.base0_r = expand5(w_head[23:19]);
            o_blk.base0_g = expand5(w_head[15:11]);
            o_blk.base0_b = expand5(w_head[7:3]);
            o_blk.base1_r = expand5(diff_sum(w_head[23:19], w_head[18:16]));
            o_blk.base1_g = expand5(diff_sum(w_head[15:11], w_head[10:8]));
            o_blk.base1_b = expand5(diff_sum(w_head[7:3], w_head[2:0]));
        end else begin
            o_blk.base0_r = expand4(w_head[23:20]);
            o_blk.base1_r = expand4(w_head[19:16]);
            o_blk.base0_g = expand4(w_head[15:12]);
            o_blk.base1_g = expand4(w_head[11:8]);
            o_blk.base0_b = expand4(w_head[7:4]);
            o_blk.base1_b = expand4(w_head[3:0]);
        end
        o_blk.tab0  = w_head[31:29];
        o_blk.tab1  = w_head[28:26];
        o_blk.flip  = w_head[etc1_pkg::FLIP_BIT];
        o_blk.idx   = i_color[63:32];
        o_blk.alpha = i_alpha;
    end

endmodule

`default_nettype wire

@@ sv/etc1_queue.sv @@
// ----------------------------------------------------------------------------
// etc1_queue
// Short queue of decoded blocks between the decode and pixel stages.
// ----------------------------------------------------------------------------
`default_nettype none

module etc1_queue #(
    parameter int unsigned DEPTH = etc1_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire etc1_pkg::t_blk  i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output etc1_pkg::t_blk       o_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    etc1_pkg::t_blk  r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/etc1_back.sv @@
// ----------------------------------------------------------------------------
// etc1_back
// Pixel sequencer: walks the 16 pixels of a decoded block in raster order
// and drives one registered pixel per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module etc1_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_alpha_en,
    input  wire logic                               i_valid,
    input  wire etc1_pkg::t_blk                     i_blk,
    output logic                                    o_pop,
    output logic                                    o_tvalid,
    input  wire logic                               i_tready,
    output logic [etc1_pkg::OUT_DATA_W-1:0]         o_tdata,
    output logic                                    o_tlast
);

    etc1_pkg::t_blk r_blk;
    logic           r_busy, n_busy;
    logic [3:0]     r_cnt, n_cnt;
    logic           r_ov, n_ov;
    logic [etc1_pkg::OUT_DATA_W-1:0] r_tdata;
    logic           r_tlast;

    logic           w_adv;
    logic           w_end;
    logic [1:0]     w_x, w_y;
    logic [3:0]     w_n;
    logic           w_sb;
    logic [1:0]     w_code;
    logic [2:0]     w_tab;
    logic signed [8:0] w_mod;
    logic [7:0]     w_r, w_g, w_b, w_a;
    logic [3:0]     w_nib;

    // pixel position: raster counter k = y*4+x, index slot n = x*4+y
    assign w_x = r_cnt[1:0];
    assign w_y = r_cnt[3:2];
    assign w_n = {w_x, w_y};

    // advance when a block is active and the output register can take a pixel
    assign w_adv = r_busy && (!r_ov || i_tready);
    assign w_end = w_adv && (r_cnt == 4'd15);
    assign o_pop = i_valid && (!r_busy || w_end);

    // pixel value
    always_comb begin
        w_sb   = r_blk.flip ? w_y[1] : w_x[1];
        w_code = {r_blk.idx[{1'b0, ~w_n[3], w_n[2:0]}],
                  r_blk.idx[{1'b1, ~w_n[3], w_n[2:0]}]};
        w_tab  = w_sb ? r_blk.tab1 : r_blk.tab0;
        w_mod  = etc1_pkg::mod_value(w_tab, w_code);
        w_r    = etc1_pkg::sat_add(w_sb ? r_blk.base1_r : r_blk.base0_r, w_mod);
        w_g    = etc1_pkg::sat_add(w_sb ? r_blk.base1_g : r_blk.base0_g, w_mod);
        w_b    = etc1_pkg::sat_add(w_sb ? r_blk.base1_b : r_blk.base0_b, w_mod);
        w_nib  = r_blk.alpha[{w_n, 2'b00} +: 4];
        w_a    = i_alpha_en ? {w_nib, w_nib} : 8'hFF;
    end

    // sequencer control
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_ov   = r_ov;
        if (w_adv) begin
            n_cnt = r_cnt + 1'b1;
            n_ov  = 1'b1;
        end else if (i_tready) begin
            n_ov  = 1'b0;
        end
        if (o_pop) begin
            n_busy = 1'b1;
        end else if (w_end) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_ov   <= n_ov;
        end
    end

    // block and output payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_blk <= i_blk;
        end
        if (w_adv) begin
            r_tdata <= {4'b0000, w_a, w_b, w_g, w_r, w_y, w_x};
            r_tlast <= (r_cnt == 4'd15);
        end
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

endmodule

`default_nettype wire

@@ sv/etc1_block_decoder.sv @@
// ----------------------------------------------------------------------------
// etc1_block_decoder
// ETC1 4x4 block decoder with optional 4-bit alpha, RGBA8 pixel stream out.
// ----------------------------------------------------------------------------
// Each block transfer (color word in tdata bits 63:0, alpha word in 127:64)
// yields 16 pixel transfers in raster order, one per cycle unless the
// master side stalls, tlast on the sixteenth. In steady state a new block
// is taken as the sequencer (one pixel per clock unless stalled) ends one.
// Block headers are decoded on entry and parked in a short queue, so a
// block is accepted while the previous one is still being streamed out.
// When idle, an accepted block passes the queue and the sequencer's block
// register before its first pixel is registered onto the master side.
// Write alpha_enabled (register 0, bit 0) only while no pixels are pending.
// ----------------------------------------------------------------------------
`default_nettype none

module etc1_block_decoder #(
    parameter int unsigned QUEUE_DEPTH = etc1_pkg::QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // block input
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [63:0] color_block, [127:64] alpha_block
    input  wire logic [etc1_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // pixel output
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [1:0] pixel_x, [3:2] pixel_y, [11:4] red, [19:12] green,
    // [27:20] blue, [35:28] alpha, [39:36] zero
    output logic [etc1_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    output logic                                    m_axis_tlast,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    logic           r_alpha_en;
    logic           w_cfg_wr;
    logic           w_full;
    logic           w_push;
    logic           w_q_valid;
    logic           w_pop;
    etc1_pkg::t_blk w_dec_blk;
    etc1_pkg::t_blk w_q_blk;

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_en <= 1'b0;
        end else if (w_cfg_wr && (paddr[2] == etc1_pkg::CFG_ALPHA_EN)) begin
            r_alpha_en <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == etc1_pkg::CFG_ALPHA_EN) begin
            prdata[0] = r_alpha_en;
        end
    end

    // header decode
    etc1_front u_front (
        .i_color (s_axis_tdata[63:0]),
        .i_alpha (s_axis_tdata[127:64]),
        .o_blk   (w_dec_blk)
    );

    // block queue
    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && s_axis_tready;

    etc1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_dec_blk),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_blk)
    );

    // pixel sequencer
    etc1_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_alpha_en (r_alpha_en),
        .i_valid    (w_q_valid),
        .i_blk      (w_q_blk),
        .o_pop      (w_pop),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tlast    (m_axis_tlast)
    );

endmodule

`default_nettype wire
